>>> hdl/b64d_pkg.sv
package b64d_pkg;

  localparam int CountBitsDefault = 24;
  localparam int QueueDepth       = 4;
  localparam logic [23:0] CapacityReset = 24'hFFFFFF;
  localparam logic [7:0]  PadChar       = 8'h3D;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_COUNT = 2'd1,
    ST_OVER_CAP  = 2'd2,
    ST_BAD_PAD   = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] in_char;
    logic       end_of_input;
  } chr_item_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        is_byte;
    status_t     status;
    logic [23:0] total_bytes;
    logic        run_last;
  } res_item_t;

  // work handed from the front to the back: bytes of one quantum and/or a status
  typedef struct packed {
    logic [23:0] quantum;
    logic [1:0]  nbytes;
    logic        has_status;
    status_t     status;
    logic [23:0] total;
  } job_t;

  typedef struct packed {
    logic       is_sym;
    logic       is_pad;
    logic [5:0] value;
  } sym_class_t;

  function automatic sym_class_t classify(input logic [7:0] c);
    sym_class_t r;
    r.is_sym = 1'b1;
    r.is_pad = 1'b0;
    r.value  = 6'd0;
    if (c inside {[8'h41:8'h5A]}) begin
      r.value = 6'(c - 8'h41);
    end else if (c inside {[8'h61:8'h7A]}) begin
      r.value = 6'(c - 8'h61 + 8'd26);
    end else if (c inside {[8'h30:8'h39]}) begin
      r.value = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      r.value = 6'd62;
    end else if (c == 8'h2F) begin
      r.value = 6'd63;
    end else if (c == PadChar) begin
      r.is_pad = 1'b1;
    end else begin
      r.is_sym = 1'b0;
    end
    return r;
  endfunction

endpackage

>>> hdl/b64d_front.sv
module b64d_front #(
  parameter int COUNT_BITS = b64d_pkg::CountBitsDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  chr_valid,
  output logic                  chr_ready,
  input  b64d_pkg::chr_item_t   chr_data,
  input  logic [23:0]           out_capacity,
  input  logic                  q_full,
  output logic                  push,
  output b64d_pkg::job_t        job
);

  localparam int CW = (COUNT_BITS > 24) ? COUNT_BITS : 24;
  localparam int QW = CW + 2;
  localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

  logic [17:0]           sextets, sextets_next;
  logic [1:0]            phase, phase_next;
  logic [1:0]            pads, pads_next;
  logic [COUNT_BITS-1:0] sym_total, sym_total_next;
  logic [COUNT_BITS-1:0] bytes_sent, bytes_sent_next;
  logic                  stopped, stopped_next;
  logic                  pad_bad, pad_bad_next;

  b64d_pkg::sym_class_t  cls;
  logic                  accept;
  logic [1:0]            nb;
  logic [COUNT_BITS:0]   bytes_sum;
  logic [CW-1:0]         bytes_w;
  logic [QW-1:0]         quarter, cap3;

  assign chr_ready = !q_full;
  assign accept    = chr_valid && !q_full;
  assign cls       = b64d_pkg::classify(chr_data.in_char);

  always_comb begin
    sextets_next    = sextets;
    phase_next      = phase;
    pads_next       = pads;
    sym_total_next  = sym_total;
    bytes_sent_next = bytes_sent;
    stopped_next    = stopped;
    pad_bad_next    = pad_bad;
    nb              = 2'd0;
    bytes_sum       = '0;
    job.quantum     = {sextets, cls.value};
    job.nbytes      = 2'd0;
    job.has_status  = chr_data.end_of_input;
    job.status      = b64d_pkg::ST_OK;
    job.total       = 24'd0;

    if (cls.is_sym) begin
      if (cls.is_pad && pads != 2'd3) pads_next = pads + 2'd1;
      if (sym_total != CountMax) sym_total_next = sym_total + 1'b1;
      if (phase != 2'd3) begin
        sextets_next = {sextets[11:0], cls.value};
        phase_next   = phase + 2'd1;
      end else begin
        if (!stopped) begin
          if (pads_next == 2'd3) begin
            pad_bad_next = 1'b1;
          end else begin
            nb = 2'd3 - pads_next;
          end
          if (pads_next != 2'd0) stopped_next = 1'b1;
          bytes_sum = {1'b0, bytes_sent} + (COUNT_BITS+1)'(nb);
          bytes_sent_next = bytes_sum[COUNT_BITS] ? CountMax : bytes_sum[COUNT_BITS-1:0];
        end
        sextets_next = 18'd0;
        phase_next   = 2'd0;
        pads_next    = 2'd0;
      end
    end
    job.nbytes = nb;

    // status uses the counts after this character
    bytes_w = CW'(bytes_sent_next);
    quarter = QW'(sym_total_next >> 2);
    cap3    = (quarter << 1) + quarter;
    if (sym_total_next == '0 || sym_total_next[1:0] != 2'd0) begin
      job.status = b64d_pkg::ST_BAD_COUNT;
    end else if (cap3 > QW'(out_capacity)) begin
      job.status = b64d_pkg::ST_OVER_CAP;
    end else if (pad_bad_next) begin
      job.status = b64d_pkg::ST_BAD_PAD;
    end else begin
      job.status = b64d_pkg::ST_OK;
      job.total  = (bytes_w > CW'(24'hFFFFFF)) ? 24'hFFFFFF : bytes_w[23:0];
    end

    if (chr_data.end_of_input) begin
      sextets_next    = 18'd0;
      phase_next      = 2'd0;
      pads_next       = 2'd0;
      sym_total_next  = '0;
      bytes_sent_next = '0;
      stopped_next    = 1'b0;
      pad_bad_next    = 1'b0;
    end
  end

  assign push = accept && (job.has_status || nb != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      sextets    <= 18'd0;
      phase      <= 2'd0;
      pads       <= 2'd0;
      sym_total  <= '0;
      bytes_sent <= '0;
      stopped    <= 1'b0;
      pad_bad    <= 1'b0;
    end else if (accept) begin
      sextets    <= sextets_next;
      phase      <= phase_next;
      pads       <= pads_next;
      sym_total  <= sym_total_next;
      bytes_sent <= bytes_sent_next;
      stopped    <= stopped_next;
      pad_bad    <= pad_bad_next;
    end
  end

endmodule

>>> hdl/b64d_queue.sv
module b64d_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  b64d_pkg::job_t  push_job,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output b64d_pkg::job_t  head_job
);

  localparam int Depth = b64d_pkg::QueueDepth;
  localparam int PW    = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  b64d_pkg::job_t  slots [Depth];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CntW-1:0] count;

  assign full       = (count == CntW'(Depth));
  assign head_valid = (count != '0);
  assign head_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= PW'((32'(wr_ptr) + 1) % Depth);
      if (pop)  rd_ptr <= PW'((32'(rd_ptr) + 1) % Depth);
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

>>> hdl/b64d_back.sv
module b64d_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 head_valid,
  input  b64d_pkg::job_t       head_job,
  output logic                 pop,
  output logic                 res_valid,
  input  logic                 res_ready,
  output b64d_pkg::res_item_t  res_data
);

  logic [1:0]          sub;
  logic                load;
  logic                is_byte;
  logic                job_last;
  b64d_pkg::res_item_t res_next;

  assign load    = head_valid && (!res_valid || res_ready);
  assign is_byte = (sub < head_job.nbytes);

  always_comb begin
    res_next.data_byte   = 8'd0;
    res_next.is_byte     = is_byte;
    res_next.status      = b64d_pkg::ST_OK;
    res_next.total_bytes = 24'd0;
    if (is_byte) begin
      case (sub)
        2'd0:    res_next.data_byte = head_job.quantum[23:16];
        2'd1:    res_next.data_byte = head_job.quantum[15:8];
        default: res_next.data_byte = head_job.quantum[7:0];
      endcase
      job_last = (sub == head_job.nbytes - 2'd1) && !head_job.has_status;
    end else begin
      res_next.status      = head_job.status;
      res_next.total_bytes = head_job.total;
      job_last             = 1'b1;
    end
    res_next.run_last = job_last;
  end

  assign pop = load && job_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      sub       <= 2'd0;
      res_valid <= 1'b0;
    end else begin
      if (load) begin
        res_valid <= 1'b1;
        sub       <= job_last ? 2'd0 : sub + 2'd1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) res_data <= res_next;
  end

endmodule

>>> hdl/base64_stream_decoder.sv
// channel  | signals                          | carries
// chr      | chr_valid, chr_ready, chr_data   | one encoded character word and end flag
// res      | res_valid, res_ready, res_data   | decoded byte word or final status word
// cfg      | cfg_wr_en, cfg_wr_data           | out_capacity, written with no wait
//
// one character word accepted per cycle while the job queue has room
// the back end sends one result word per cycle while res_ready is high, so a full
// quantum (3 bytes, plus a status on the last character) holds it for each word
// a 4-entry job queue absorbs that; a result goes via a queue slot to res_data
// reset is synchronous: message state cleared, out_capacity back to 0xFFFFFF
// res stalls back up through the queue to chr_ready only when the queue fills
module base64_stream_decoder #(
  parameter int COUNT_BITS = b64d_pkg::CountBitsDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 chr_valid,
  output logic                 chr_ready,
  input  b64d_pkg::chr_item_t  chr_data,
  output logic                 res_valid,
  input  logic                 res_ready,
  output b64d_pkg::res_item_t  res_data,
  input  logic                 cfg_wr_en,
  input  logic [23:0]          cfg_wr_data
);

  // capacity register, compared against symbols/4*3 at message end
  logic [23:0] out_capacity;

  // front to queue
  logic           push;
  logic           q_full;
  b64d_pkg::job_t push_job;

  // queue to back
  logic           pop;
  logic           head_valid;
  b64d_pkg::job_t head_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity <= b64d_pkg::CapacityReset;
    end else if (cfg_wr_en) begin
      out_capacity <= cfg_wr_data;
    end
  end

  // front: alphabet lookup, quantum assembly, counters, final status
  b64d_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .chr_valid    (chr_valid),
    .chr_ready    (chr_ready),
    .chr_data     (chr_data),
    .out_capacity (out_capacity),
    .q_full       (q_full),
    .push         (push),
    .job          (push_job)
  );

  // short job queue so the two sides stall independently
  b64d_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // back: splits each job into byte words and the status word
  b64d_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_data   (res_data)
  );

  // a status word always closes the results of its character
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_data.is_byte |-> res_data.run_last)
    else $error("status word without run_last");

  // byte words carry no status and no total
  a_byte_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.is_byte |->
      res_data.status == b64d_pkg::ST_OK && res_data.total_bytes == 24'd0)
    else $error("byte word with status or total");

  // an error status reports no length
  a_err_total: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_data.is_byte && res_data.status != b64d_pkg::ST_OK |->
      res_data.total_bytes == 24'd0)
    else $error("error status with nonzero total");

  // the queue only pops a job that the back end has loaded
  a_pop_head: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty job queue");

endmodule
